// ===== rtl/sth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sth_pkg
// shared constants and types of the slope trick heap engine
// ----------------------------------------------------------------------------
package sth_pkg;

    localparam int HEAP_DEPTH = 1024;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int DATA_W     = 64;

    typedef enum logic [2:0] {
        F_RAMP_R  = 3'd0,
        F_RAMP_L  = 3'd1,
        F_RAMP_LR = 3'd2,
        F_ADD_MIN = 3'd3,
        F_SLIDE_L = 3'd4,
        F_SLIDE_R = 3'd5,
        F_CLR_R   = 3'd6,
        F_CLR_L   = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_REPLACE = 2'd2
    } t_cell_op;

    // command broadcast along a row of cells
    typedef struct packed {
        t_cell_op           op;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   count;
        logic               max_heap;
    } t_row_cmd;

endpackage

// ===== rtl/sth_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sth_cell
// one slot of a sorted row: holds one breakpoint, shifts with its neighbors
// ----------------------------------------------------------------------------
module sth_cell (
    input  logic                      i_clk,
    input  sth_pkg::t_row_cmd         i_cmd,
    input  logic                      i_live,
    input  logic [sth_pkg::DATA_W-1:0] i_prev_val,
    input  logic                      i_prev_g,
    input  logic [sth_pkg::DATA_W-1:0] i_next_val,
    input  logic                      i_next_g,
    output logic [sth_pkg::DATA_W-1:0] o_val,
    output logic                      o_g
);

    logic [sth_pkg::DATA_W-1:0] r_val;
    logic [sth_pkg::DATA_W-1:0] n_val;

    // g: the command value ranks above this slot (empty slots rank lowest)
    assign o_g = !i_live || (i_cmd.max_heap ?
                 ($signed(i_cmd.value) > $signed(r_val)) :
                 ($signed(i_cmd.value) < $signed(r_val)));
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            sth_pkg::OP_INSERT: begin
                if (i_prev_g) begin
                    n_val = i_prev_val;
                end else if (o_g) begin
                    n_val = i_cmd.value;
                end
            end
            sth_pkg::OP_REPLACE: begin
                // drop the top, then insert
                if (o_g) begin
                    n_val = r_val;
                end else if (i_next_g) begin
                    n_val = i_cmd.value;
                end else begin
                    n_val = i_next_val;
                end
            end
            default: n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== rtl/sth_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sth_row
// chain of cells kept sorted so that cell zero is the heap top
// ----------------------------------------------------------------------------
module sth_row (
    input  logic                       i_clk,
    input  sth_pkg::t_row_cmd          i_cmd,
    output logic [sth_pkg::DATA_W-1:0] o_top
);

    logic [sth_pkg::DATA_W-1:0] w_val [sth_pkg::HEAP_DEPTH];
    logic                       w_g   [sth_pkg::HEAP_DEPTH];

    for (genvar i = 0; i < sth_pkg::HEAP_DEPTH; i++) begin : g_cell
        logic [sth_pkg::DATA_W-1:0] w_pv;
        logic                       w_pg;
        logic [sth_pkg::DATA_W-1:0] w_nv;
        logic                       w_ng;
        logic                       w_live;

        assign w_live = (sth_pkg::CNT_W'(i) < i_cmd.count);

        if (i == 0) begin : g_first
            assign w_pv = '0;
            assign w_pg = 1'b0;
        end else begin : g_mid_p
            assign w_pv = w_val[i-1];
            assign w_pg = w_g[i-1];
        end

        if (i == sth_pkg::HEAP_DEPTH - 1) begin : g_last
            assign w_nv = '0;
            assign w_ng = 1'b1;
        end else begin : g_mid_n
            assign w_nv = w_val[i+1];
            assign w_ng = w_g[i+1];
        end

        sth_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_live     (w_live),
            .i_prev_val (w_pv),
            .i_prev_g   (w_pg),
            .i_next_val (w_nv),
            .i_next_g   (w_ng),
            .o_val      (w_val[i]),
            .o_g        (w_g[i])
        );
    end

    assign o_top = w_val[0];

endmodule

// ===== rtl/slope_trick_heap_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_trick_heap_engine
// convex piecewise-linear function kept as two sorted rows of breakpoints
// ----------------------------------------------------------------------------
// latency follows the states passed: offset, constant, clear and refused items
// go straight to S_OUT; ramps pass S_R1, S_R2 and/or S_L1, S_L2 before it
// throughput: one item in flight; next word taken the cycle after the result is
// loaded; S_OUT holds while the previous result word is not yet taken
// reset: counts, offsets and minimum clear; row contents stay undefined
// ----------------------------------------------------------------------------
module slope_trick_heap_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // operand
    input  logic [2:0]   i_s_axis_tuser,   // func
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [199:0] o_m_axis_tdata,   // min_value, flat_low, flat_high,
                                           // low_open, high_open, zero pad
    output logic [0:0]   o_m_axis_tuser    // status
);

    localparam int DW = sth_pkg::DATA_W;
    localparam int CW = sth_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_R1, S_R2, S_L1, S_L2, S_OUT
    } t_state;

    t_state              r_state;
    sth_pkg::t_func      r_func;
    logic [DW-1:0]       r_v;
    logic [DW-1:0]       r_x;
    logic                r_status;
    logic [CW-1:0]       r_lcnt;
    logic [CW-1:0]       r_rcnt;
    logic [DW-1:0]       r_min;
    logic [DW-1:0]       r_loff;
    logic [DW-1:0]       r_roff;
    logic                r_mvalid;
    logic [199:0]        r_mdata;
    logic                r_muser;

    logic [DW-1:0]       w_ltop;
    logic [DW-1:0]       w_rtop;
    sth_pkg::t_row_cmd   w_lcmd;
    sth_pkg::t_row_cmd   w_rcmd;
    logic [DW-1:0]       w_lv;
    logic [DW-1:0]       w_rv;
    logic                w_lrep;
    logic                w_rrep;
    logic [DW-1:0]       w_ld;
    logic [DW-1:0]       w_rd;
    logic                w_lfull;
    logic                w_rfull;

    assign w_lv    = r_v - r_loff;
    assign w_rv    = r_v - r_roff;
    assign w_lrep  = (r_lcnt != '0) && ($signed(w_ltop) > $signed(w_lv));
    assign w_rrep  = (r_rcnt != '0) && ($signed(w_rtop) < $signed(w_rv));
    assign w_ld    = w_ltop + r_loff - r_v;
    assign w_rd    = r_v - (w_rtop + r_roff);
    assign w_lfull = (r_lcnt == CW'(sth_pkg::HEAP_DEPTH));
    assign w_rfull = (r_rcnt == CW'(sth_pkg::HEAP_DEPTH));

    always_comb begin
        w_lcmd.op       = sth_pkg::OP_HOLD;
        w_lcmd.value    = w_lv;
        w_lcmd.count    = r_lcnt;
        w_lcmd.max_heap = 1'b1;
        w_rcmd.op       = sth_pkg::OP_HOLD;
        w_rcmd.value    = w_rv;
        w_rcmd.count    = r_rcnt;
        w_rcmd.max_heap = 1'b0;
        unique case (r_state)
            S_R1: if (w_lrep) w_lcmd.op = sth_pkg::OP_REPLACE;
            S_R2: begin
                w_rcmd.op    = sth_pkg::OP_INSERT;
                w_rcmd.value = r_x - r_roff;
            end
            S_L1: if (w_rrep) w_rcmd.op = sth_pkg::OP_REPLACE;
            S_L2: begin
                w_lcmd.op    = sth_pkg::OP_INSERT;
                w_lcmd.value = r_x - r_loff;
            end
            default: ;
        endcase
    end

    sth_row u_left  (.i_clk(i_clk), .i_cmd(w_lcmd), .o_top(w_ltop));
    sth_row u_right (.i_clk(i_clk), .i_cmd(w_rcmd), .o_top(w_rtop));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_min    <= '0;
            r_loff   <= '0;
            r_roff   <= '0;
            r_mvalid <= 1'b0;
            r_status <= 1'b0;
        end else begin
            // in S_OUT the load below decides the valid flag
            if (r_mvalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_func   <= sth_pkg::t_func'(i_s_axis_tuser);
                        r_v      <= i_s_axis_tdata;
                        unique case (sth_pkg::t_func'(i_s_axis_tuser))
                            sth_pkg::F_RAMP_R: begin
                                r_status <= w_rfull;
                                r_state  <= w_rfull ? S_OUT : S_R1;
                            end
                            sth_pkg::F_RAMP_L: begin
                                r_status <= w_lfull;
                                r_state  <= w_lfull ? S_OUT : S_L1;
                            end
                            sth_pkg::F_RAMP_LR: begin
                                r_status <= w_lfull || w_rfull;
                                r_state  <= (w_lfull || w_rfull) ? S_OUT : S_R1;
                            end
                            sth_pkg::F_ADD_MIN: begin
                                r_min    <= r_min + i_s_axis_tdata;
                                r_status <= 1'b0;
                                r_state  <= S_OUT;
                            end
                            sth_pkg::F_SLIDE_L: begin
                                r_loff   <= r_loff + i_s_axis_tdata;
                                r_status <= 1'b0;
                                r_state  <= S_OUT;
                            end
                            sth_pkg::F_SLIDE_R: begin
                                r_roff   <= r_roff + i_s_axis_tdata;
                                r_status <= 1'b0;
                                r_state  <= S_OUT;
                            end
                            sth_pkg::F_CLR_R: begin
                                r_rcnt   <= '0;
                                r_status <= 1'b0;
                                r_state  <= S_OUT;
                            end
                            default: begin
                                r_lcnt   <= '0;
                                r_status <= 1'b0;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_R1: begin
                    if (r_lcnt == '0) begin
                        r_x <= r_v;
                    end else begin
                        r_x <= (w_lrep ? w_ltop : w_lv) + r_loff;
                        if (!w_ld[DW-1]) r_min <= r_min + w_ld;
                    end
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_rcnt  <= r_rcnt + CW'(1);
                    r_state <= (r_func == sth_pkg::F_RAMP_LR) ? S_L1 : S_OUT;
                end
                S_L1: begin
                    if (r_rcnt == '0) begin
                        r_x <= r_v;
                    end else begin
                        r_x <= (w_rrep ? w_rtop : w_rv) + r_roff;
                        if (!w_rd[DW-1]) r_min <= r_min + w_rd;
                    end
                    r_state <= S_L2;
                end
                S_L2: begin
                    r_lcnt  <= r_lcnt + CW'(1);
                    r_state <= S_OUT;
                end
                default: begin
                    if (!r_mvalid || i_m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_muser  <= r_status;
                        r_mdata  <= {6'd0,
                                     (r_rcnt == '0),
                                     (r_lcnt == '0),
                                     (r_rcnt != '0) ? w_rtop + r_roff : {DW{1'b0}},
                                     (r_lcnt != '0) ? w_ltop + r_loff : {DW{1'b0}},
                                     r_min};
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;
    assign o_m_axis_tuser  = r_muser;

endmodule

// ===== rtl/sth_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sth_checker
// port-level checks of the slope trick heap engine
// ----------------------------------------------------------------------------
module sth_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [199:0] o_m_axis_tdata
);

    // a result word waits until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped");

    // one item in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word taken while busy");

    // no result in the cycle right after an accept
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !$rose(o_m_axis_tvalid))
        else $error("result too early");

    // an open low bound reports zero
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[192] |-> o_m_axis_tdata[127:64] == '0)
        else $error("open low bound not zero");

endmodule

bind slope_trick_heap_engine sth_checker u_sth_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/slope_trick_heap_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_trick_heap_engine_tb
// self-checking bench: directed table, heap fill to overflow, random ramps,
// slides and clears, each result checked against a table or a breakpoint model
// ----------------------------------------------------------------------------
module slope_trick_heap_engine_tb;

    localparam int  LIMIT = 3_000_000;
    localparam int  SIDE_L = 0;
    localparam int  SIDE_R = 1;

    typedef struct packed {
        logic [63:0] min_value;
        logic [63:0] flat_low;
        logic [63:0] flat_high;
        logic        low_open;
        logic        high_open;
        logic        status;
    } t_summary;

    typedef struct {
        sth_pkg::t_func func;
        logic [63:0]    operand;
        bit             known;
        t_summary       want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [63:0]  i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [199:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;

    // breakpoint model: index 0 left (max-heap), 1 right (min-heap)
    logic [63:0] bp_heap [2][sth_pkg::HEAP_DEPTH];
    int unsigned bp_count [2];
    logic [63:0] bp_offset [2];
    logic [63:0] fn_minimum;

    t_row        rows [$];
    t_summary    pending_q [$];
    int          n_errors;
    int          n_items;
    int          n_results;
    int          n_refused;
    int unsigned cycles = 0;
    bit          stall_heavy;

    slope_trick_heap_engine u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void queue_row(sth_pkg::t_func f, logic [63:0] v, bit known,
                                      t_summary want);
        rows.insert(rows.size(), '{f, v, known, want});
    endfunction

    function automatic bit ranks_over(logic [63:0] x, logic [63:0] y, int s);
        return (s == SIDE_L) ? ($signed(x) > $signed(y)) : ($signed(x) < $signed(y));
    endfunction

    function automatic void bp_insert(int s, logic [63:0] v);
        int unsigned i;
        int unsigned p;
        i = bp_count[s];
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_over(v, bp_heap[s][p], s)) break;
            bp_heap[s][i] = bp_heap[s][p];
            i = p;
        end
        bp_heap[s][i] = v;
        bp_count[s]++;
    endfunction

    // push v and pop the top in one step
    function automatic logic [63:0] bp_replace(int s, logic [63:0] v);
        logic [63:0] top;
        int unsigned i;
        int unsigned c;
        i = 0;
        if (bp_count[s] == 0 || !ranks_over(bp_heap[s][0], v, s)) return v;
        top = bp_heap[s][0];
        forever begin
            c = 2 * i + 1;
            if (c >= bp_count[s]) break;
            if (c + 1 < bp_count[s] && ranks_over(bp_heap[s][c+1], bp_heap[s][c], s))
                c++;
            if (!ranks_over(bp_heap[s][c], v, s)) break;
            bp_heap[s][i] = bp_heap[s][c];
            i = c;
        end
        bp_heap[s][i] = v;
        return top;
    endfunction

    // s is the side the new breakpoint lands on first when the other is empty
    function automatic void add_ramp(int s, logic [63:0] a);
        int o;
        logic [63:0] top0;
        logic [63:0] moved;
        logic [63:0] d;
        o = 1 - s;
        if (bp_count[o] == 0) begin
            bp_insert(s, a - bp_offset[s]);
        end else begin
            top0  = bp_heap[o][0] + bp_offset[o];
            moved = bp_replace(o, a - bp_offset[o]) + bp_offset[o];
            bp_insert(s, moved - bp_offset[s]);
            d = (s == SIDE_R) ? top0 - a : a - top0;
            if (!d[63]) fn_minimum += d;
        end
    endfunction

    function automatic t_summary apply_word(sth_pkg::t_func f, logic [63:0] v);
        t_summary r;
        bit lfull;
        bit rfull;
        lfull = bp_count[SIDE_L] >= sth_pkg::HEAP_DEPTH;
        rfull = bp_count[SIDE_R] >= sth_pkg::HEAP_DEPTH;
        r.status = 1'b0;
        case (f)
            sth_pkg::F_RAMP_R:  if (rfull) r.status = 1'b1; else add_ramp(SIDE_R, v);
            sth_pkg::F_RAMP_L:  if (lfull) r.status = 1'b1; else add_ramp(SIDE_L, v);
            sth_pkg::F_RAMP_LR: begin
                if (lfull || rfull) begin
                    r.status = 1'b1;
                end else begin
                    add_ramp(SIDE_R, v);
                    add_ramp(SIDE_L, v);
                end
            end
            sth_pkg::F_ADD_MIN: fn_minimum += v;
            sth_pkg::F_SLIDE_L: bp_offset[SIDE_L] += v;
            sth_pkg::F_SLIDE_R: bp_offset[SIDE_R] += v;
            sth_pkg::F_CLR_R:   bp_count[SIDE_R] = 0;
            default:            bp_count[SIDE_L] = 0;
        endcase
        r.min_value = fn_minimum;
        r.low_open  = (bp_count[SIDE_L] == 0);
        r.high_open = (bp_count[SIDE_R] == 0);
        r.flat_low  = r.low_open ? 64'd0 : bp_heap[SIDE_L][0] + bp_offset[SIDE_L];
        r.flat_high = r.high_open ? 64'd0 : bp_heap[SIDE_R][0] + bp_offset[SIDE_R];
        return r;
    endfunction

    // one word on the input side; the gap before it is random
    task automatic send_word(sth_pkg::t_func f, logic [63:0] v, bit known, t_summary want);
        int r;
        int gap;
        t_summary got;
        r = $urandom_range(0, 19);
        gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(6, 40);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= f;
        i_s_axis_tdata  <= v;
        do @(posedge i_clk); while (!o_s_axis_tready);
        got = apply_word(f, v);
        pending_q.insert(pending_q.size(), known ? want : got);
        n_items++;
        if (got.status) n_refused++;
    endtask

    function automatic logic [63:0] rand_operand();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return {1'b0, {63{1'b1}}};
            1:       return {1'b1, 63'd0};
            2, 3:    return {$urandom, $urandom};
            default: return 64'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // output side: random stalls, in stretches of heavy and of light stalling
    always @(posedge i_clk) begin
        t_summary got;
        t_summary want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_heavy     <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_heavy <= ~stall_heavy;
            i_m_axis_tready <= stall_heavy ? ($urandom_range(0, 9) < 3)
                                           : ($urandom_range(0, 19) != 0);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.min_value = o_m_axis_tdata[63:0];
                got.flat_low  = o_m_axis_tdata[127:64];
                got.flat_high = o_m_axis_tdata[191:128];
                got.low_open  = o_m_axis_tdata[192];
                got.high_open = o_m_axis_tdata[193];
                got.status    = o_m_axis_tuser[0];
                n_results++;
                if (pending_q.size() == 0) begin
                    $error("result word with nothing expected");
                    n_errors++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.min_value !== want.min_value) begin
                        $error("min_value exp %h got %h", want.min_value, got.min_value);
                        n_errors++;
                    end
                    if (got.flat_low !== want.flat_low) begin
                        $error("flat_low exp %h got %h", want.flat_low, got.flat_low);
                        n_errors++;
                    end
                    if (got.flat_high !== want.flat_high) begin
                        $error("flat_high exp %h got %h", want.flat_high, got.flat_high);
                        n_errors++;
                    end
                    if (got.low_open !== want.low_open) begin
                        $error("low_open exp %b got %b", want.low_open, got.low_open);
                        n_errors++;
                    end
                    if (got.high_open !== want.high_open) begin
                        $error("high_open exp %b got %b", want.high_open, got.high_open);
                        n_errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status exp %b got %b", want.status, got.status);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("slope_trick_heap_engine regression: fail");
            $finish;
        end
    end

    initial begin
        t_summary       none;
        sth_pkg::t_func f;
        int             r;
        logic [63:0]    top;
        logic [63:0]    low;
        none = '0;
        n_errors = 0;
        n_items = 0;
        n_results = 0;
        n_refused = 0;
        bp_count = '{0, 0};
        bp_offset = '{64'd0, 64'd0};
        fn_minimum = 64'd0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 64'd0;
        i_s_axis_tuser = sth_pkg::F_ADD_MIN;
        top = {1'b0, {63{1'b1}}};
        low = {1'b1, 63'd0};

        // typed rows: minimum wraps, slides and clears on an empty function
        queue_row(sth_pkg::F_ADD_MIN, top, 1'b1,
                  '{top, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_ADD_MIN, 64'd1, 1'b1,
                  '{low, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_ADD_MIN, low, 1'b1,
                  '{64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_SLIDE_L, '1, 1'b1,
                  '{64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_SLIDE_R, top, 1'b1,
                  '{64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_CLR_R, 64'd0, 1'b1,
                  '{64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        queue_row(sth_pkg::F_CLR_L, 64'd0, 1'b1,
                  '{64'd0, 64'd0, 64'd0, 1'b1, 1'b1, 1'b0});
        // ramps checked against the model, including wrap of the penalty
        queue_row(sth_pkg::F_RAMP_R, 64'd0, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_L, top, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_LR, low, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_LR, 64'd5, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_R, -64'sd3, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_L, 64'd100, 1'b0, none);
        queue_row(sth_pkg::F_SLIDE_L, 64'd10, 1'b0, none);
        queue_row(sth_pkg::F_SLIDE_R, -64'sd10, 1'b0, none);
        queue_row(sth_pkg::F_ADD_MIN, -64'sd7, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_LR, '1, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_L, top, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_R, low, 1'b0, none);
        queue_row(sth_pkg::F_CLR_R, 64'd0, 1'b0, none);
        queue_row(sth_pkg::F_RAMP_L, 64'd42, 1'b0, none);
        queue_row(sth_pkg::F_CLR_L, 64'd0, 1'b0, none);
        queue_row(sth_pkg::F_CLR_R, 64'd0, 1'b0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_word(rows[k].func, rows[k].operand, rows[k].known, rows[k].want);

        // absolute ramps grow both rows by one, so this fills both to the brim
        for (int k = 0; k < sth_pkg::HEAP_DEPTH; k++)
            send_word(sth_pkg::F_RAMP_LR, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_RAMP_L, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_RAMP_R, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_RAMP_LR, rand_operand(), 1'b0, none);
        // full left row: right ramp only replaces on it
        send_word(sth_pkg::F_CLR_R, 64'd0, 1'b0, none);
        send_word(sth_pkg::F_RAMP_R, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_RAMP_L, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_RAMP_LR, rand_operand(), 1'b0, none);
        send_word(sth_pkg::F_CLR_L, 64'd0, 1'b0, none);
        send_word(sth_pkg::F_CLR_R, 64'd0, 1'b0, none);

        // random mix, ramps dominant so both rows stay populated
        for (int k = 0; k < 50; k++) begin
            r = $urandom_range(0, 99);
            if (r < 25) f = sth_pkg::F_RAMP_R;
            else if (r < 50) f = sth_pkg::F_RAMP_L;
            else if (r < 70) f = sth_pkg::F_RAMP_LR;
            else if (r < 78) f = sth_pkg::F_ADD_MIN;
            else if (r < 86) f = sth_pkg::F_SLIDE_L;
            else if (r < 94) f = sth_pkg::F_SLIDE_R;
            else if (r < 97) f = sth_pkg::F_CLR_R;
            else f = sth_pkg::F_CLR_L;
            send_word(f, rand_operand(), 1'b0, none);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d words in (%0d refused on a full row), %0d results checked",
                 n_items, n_refused, n_results);
        $display("covered: every opcode, operand extremes, both rows filled to depth");
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("slope_trick_heap_engine regression: pass");
        end else begin
            $display("slope_trick_heap_engine regression: fail");
        end
        $finish;
    end

endmodule
